>>> rtl/core/tlv_crash_record_parser_top_macros.svh
// Assertion macros shared by the crash-record parser RTL.
// Needs clk and rst_n in scope at the place of use.
`ifndef TLV_CRASH_RECORD_PARSER_TOP_MACROS_SVH
`define TLV_CRASH_RECORD_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define TLVCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TLVCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tlvcr_pkg.sv
// Types, codes and helpers for the crash-record parser.
// No dependencies; used by every module in rtl/core.
package tlvcr_pkg;

    localparam int ADDR_BYTES = 4;
    localparam int PC_W       = 8 * ADDR_BYTES;

    // word fields
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    typedef enum logic [3:0] {
        PH_EVENT = 4'b0001,
        PH_RHDR  = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    localparam logic [1:0] KIND_EVENT   = 2'd0;
    localparam logic [1:0] KIND_RHDR    = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_COMPLETE  = 3'd1;
    localparam logic [2:0] ST_BAD_CODE  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_HDR_TRUNC = 3'd4;
    localparam logic [2:0] ST_REC_ERR   = 3'd5;

    localparam logic [7:0] EVENT_CODE   = 8'hFF;

    localparam logic [7:0] T_FIRST_KNOWN = 8'h01;
    localparam logic [7:0] T_LAST_KNOWN  = 8'h07;
    localparam logic [7:0] T_AUX_REGS    = 8'h06;

    typedef struct packed {
        logic [7:0] dump_byte;
        logic       end_of_dump;
    } item_t;

    typedef struct packed {
        logic [1:0]      record_kind;
        logic [7:0]      record_type;
        logic [7:0]      value_offset;
        logic [7:0]      data_byte;
        logic [2:0]      status;
        logic            finished;
        logic            pc_found;
        logic [PC_W-1:0] pc_value;
    } result_t;

    function automatic logic type_known(input logic [7:0] t);
        type_known = (t >= T_FIRST_KNOWN) && (t <= T_LAST_KNOWN);
    endfunction

    // fixed value sizes of the known record types
    function automatic logic size_ok(input logic [7:0] t, input logic [7:0] len);
        case (t)
            8'h01:   size_ok = (len == 8'd1);
            8'h02:   size_ok = (len == 8'd2);
            8'h03:   size_ok = (len == 8'd1);
            8'h04:   size_ok = (len == 8'd1);
            8'h05:   size_ok = (len == 8'(5 * ADDR_BYTES));
            8'h06:   size_ok = (len == 8'(4 * ADDR_BYTES)) || (len == 8'(7 * ADDR_BYTES));
            8'h07:   size_ok = (len == 8'd1);
            default: size_ok = 1'b1;
        endcase
    endfunction

endpackage

>>> rtl/core/tlvcr_in_stage.sv
// Input register of the crash-record parser: holds one accepted byte.
// Depends on tlvcr_pkg.
module tlvcr_in_stage
    import tlvcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] dump_byte
    input  logic       s_tlast,   // end_of_dump
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.dump_byte   <= s_tdata;
            item_reg.end_of_dump <= s_tlast;
        end
    end

endmodule

>>> rtl/core/tlvcr_parse.sv
// Parser state and per-byte tagging logic of the crash-record parser.
// Depends on tlvcr_pkg and the assertion macro header.
`include "tlv_crash_record_parser_top_macros.svh"

module tlvcr_parse
    import tlvcr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t res
);

    localparam logic [7:0] PC_FIRST = 8'(ADDR_BYTES);
    localparam logic [7:0] PC_LAST  = 8'(2 * ADDR_BYTES - 1);

    phase_t          phase_reg,  phase_next;
    logic [7:0]      count_reg,  count_next;
    logic [7:0]      type_reg,   type_next;
    logic [7:0]      len_reg,    len_next;
    logic [8:0]      rem_reg,    rem_next;
    logic [PC_W-1:0] pc_reg,     pc_next;
    logic            seen_reg,   seen_next;
    logic [2:0]      fstat_reg,  fstat_next;

    logic [7:0]  b;
    logic        eod;
    logic [2:0]  st;
    logic [1:0]  kind;
    logic [7:0]  rtype;
    logic [7:0]  eff_len;
    logic [9:0]  len_plus2;
    logic        early_ok;
    logic [10:0] rem_left;
    logic        rec_bad;

    assign b   = item.dump_byte;
    assign eod = item.end_of_dump;

    // length that an early end inside the value is judged against
    assign eff_len   = (phase_reg == PH_RHDR) ? b : len_reg;
    assign len_plus2 = {2'b0, eff_len} + 10'd2;
    assign early_ok  = !type_known(type_reg) && ({1'b0, rem_reg} <= len_plus2);
    assign rem_left  = {2'b0, rem_reg} - {3'b0, len_reg} - 11'd2;
    assign rec_bad   = !size_ok(type_reg, b) || (b == 8'd0) || ({1'b0, b} > rem_reg);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        pc_next    = pc_reg;
        seen_next  = seen_reg;
        fstat_next = fstat_reg;
        st         = ST_RUNNING;
        kind       = KIND_IGNORED;
        rtype      = 8'd0;

        case (phase_reg)
            PH_EVENT:
            begin
                kind = KIND_EVENT;
                if (count_reg == 8'd0)
                begin
                    type_next = b;
                end
                if (count_reg == 8'd1)
                begin
                    len_next = b;
                end
                if (count_reg < 8'd4)
                begin
                    count_next = count_reg + 8'd1;
                    if (eod)
                    begin
                        st = ST_HDR_TRUNC;
                    end
                end
                else if (type_reg != EVENT_CODE)
                begin
                    st = ST_BAD_CODE;
                end
                else if (len_reg <= 8'd3)
                begin
                    st = ST_BAD_LEN;
                end
                else
                begin
                    rem_next   = {1'b0, len_reg} - 9'd3;
                    phase_next = PH_RHDR;
                    count_next = 8'd0;
                    type_next  = 8'd0;
                    len_next   = 8'd0;
                    if (eod)
                    begin
                        st = ST_REC_ERR;
                    end
                end
            end
            PH_RHDR:
            begin
                kind = KIND_RHDR;
                if (count_reg == 8'd0)
                begin
                    type_next  = b;
                    rtype      = b;
                    count_next = 8'd1;
                    if (eod)
                    begin
                        st = ST_REC_ERR;
                    end
                end
                else
                begin
                    rtype    = type_reg;
                    len_next = b;
                    if (rec_bad)
                    begin
                        st = ST_REC_ERR;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                        count_next = 8'd0;
                        if (eod)
                        begin
                            st = early_ok ? ST_COMPLETE : ST_REC_ERR;
                        end
                    end
                end
            end
            PH_VALUE:
            begin
                kind  = KIND_VALUE;
                rtype = type_reg;
                // program counter bytes of an aux-register record, big-endian
                if (type_reg == T_AUX_REGS && count_reg >= PC_FIRST && count_reg <= PC_LAST)
                begin
                    pc_next = {pc_reg[PC_W-9:0], b};
                    if (count_reg == PC_LAST)
                    begin
                        seen_next = 1'b1;
                    end
                end
                if ({1'b0, count_reg} + 9'd1 >= {1'b0, len_reg})
                begin
                    if (rem_left[10] || rem_left == 11'd0)
                    begin
                        rem_next = 9'd0;
                        st       = ST_COMPLETE;
                    end
                    else
                    begin
                        rem_next   = rem_left[8:0];
                        phase_next = PH_RHDR;
                        count_next = 8'd0;
                        if (eod)
                        begin
                            st = ST_REC_ERR;
                        end
                    end
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                    if (eod)
                    begin
                        st = early_ok ? ST_COMPLETE : ST_REC_ERR;
                    end
                end
            end
            default:
            begin
                kind = KIND_IGNORED;
                st   = fstat_reg;
            end
        endcase

        res.finished = (phase_reg != PH_DONE) && (st != ST_RUNNING);
        if (res.finished)
        begin
            fstat_next = st;
            phase_next = PH_DONE;
        end

        res.record_kind  = kind;
        res.record_type  = rtype;
        res.value_offset = (phase_reg == PH_DONE) ? 8'd0 : count_reg;
        res.data_byte    = b;
        res.status       = st;
        res.pc_found     = seen_next;
        res.pc_value     = seen_next ? pc_next : '0;

        // end mark: back to the start for the next dump
        if (eod)
        begin
            phase_next = PH_EVENT;
            count_next = 8'd0;
            type_next  = 8'd0;
            len_next   = 8'd0;
            rem_next   = 9'd0;
            pc_next    = '0;
            seen_next  = 1'b0;
            fstat_next = ST_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EVENT;
            count_reg <= 8'd0;
            type_reg  <= 8'd0;
            len_reg   <= 8'd0;
            rem_reg   <= 9'd0;
            pc_reg    <= '0;
            seen_reg  <= 1'b0;
            fstat_reg <= ST_RUNNING;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            pc_reg    <= pc_next;
            seen_reg  <= seen_next;
            fstat_reg <= fstat_next;
        end
    end

    `TLVCR_ASSERT_NOW(a_fin_has_status, step && res.finished, res.status != ST_RUNNING, "finished with running status")
    `TLVCR_ASSERT_NOW(a_ignored_not_fin, step && res.record_kind == KIND_IGNORED, !res.finished, "ignored byte marked finished")
    `TLVCR_ASSERT_NOW(a_pc_zero, step && !res.pc_found, res.pc_value == '0, "counter shown before found")
    `TLVCR_ASSERT_NEXT(a_eod_resets, step && eod, phase_reg == PH_EVENT && !seen_reg && count_reg == 8'd0, "state not reset after end mark")

endmodule

>>> rtl/core/tlvcr_out_stage.sv
// Result register of the crash-record parser and the master-side word packing.
// Depends on tlvcr_pkg.
module tlvcr_out_stage
    import tlvcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  result_t               res,
    output logic                  advance,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,
    output logic                  m_tlast
);

    logic    valid_reg;
    result_t res_reg;

    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.record_kind;
    assign m_tlast  = res_reg.finished;
    assign m_tdata  = {4'b0, res_reg.pc_value, res_reg.pc_found, res_reg.status,
                       res_reg.data_byte, res_reg.value_offset, res_reg.record_type};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && advance)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> rtl/core/tlv_crash_record_parser_top.sv
// Top level of the crash-record TLV parser: byte stream in, tagged words out.
// Depends on tlvcr_pkg, tlvcr_in_stage, tlvcr_parse and tlvcr_out_stage.
//
// Usage
//   Slave side: one dump byte per word in s_tdata[7:0]; s_tlast marks the
//   final byte of a dump. Master side: one tagged word per input byte, in
//   order. m_tuser carries the record kind (event header, record header,
//   record value, ignored after finish); m_tlast is set on the byte on which
//   parsing ended (complete or first error).
//   A byte taken into the input register is tagged by the parse logic
//   and captured in the result register when the master side is free.
//   Throughput: one byte per cycle while m_tready is high; the input and
//   result registers keep both sides moving, the parse step is combinational.
//   Stall: when m_tready is low with a word waiting, the result register
//   holds, and the input register takes at most one more byte before
//   s_tready drops.
//   Reset: rst_n clears both registers' valid flags and the parser state to
//   the start of an event header. A word with s_tlast also returns the
//   parser to that state, program counter latch included, once tagged.
module tlv_crash_record_parser_top
    import tlvcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] dump_byte
    input  logic                  s_tlast,   // end_of_dump
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] record_type, [15:8] value_offset, [23:16] data_byte,
    // [26:24] status, [27] pc_found, [59:28] pc_value, [63:60] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,   // [1:0] record_kind
    output logic                  m_tlast    // finished
);

    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t res;

    tlvcr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // state advances only when the byte moves into the result register
    tlvcr_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (item_valid && advance),
        .item  (item),
        .res   (res)
    );

    tlvcr_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res        (res),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> test/tlv_crash_record_parser_top_test.sv
// Self-checking bench for tlv_crash_record_parser_top: dump bytes in, tagged words checked.
// Needs tlvcr_pkg and the parser RTL; an in-order predictor in a small scoreboard
// class tags every accepted byte and checks each word that leaves the master side.
module tlv_crash_record_parser_top_test
    import tlvcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         EVENT_OVERHEAD = 3;       // code, length, first prefix byte
    localparam logic [7:0] HDR_LAST       = 8'd4;    // offset of the fifth header byte
    localparam logic [7:0] AUX_LONG_SIZE  = 8'(7 * ADDR_BYTES);
    localparam int         RUN_BYTES      = 1350;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         CYCLE_LIMIT    = 400000;

    // value sizes of the known types, indexed by type byte; the aux type also takes the long size
    localparam logic [7:0][7:0] KNOWN_SIZE = {8'd1, 8'(4 * ADDR_BYTES), 8'(5 * ADDR_BYTES),
                                              8'd1, 8'd1, 8'd2, 8'd1, 8'd0};

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    bit    calm;            // no idling on either side while set
    int    sent_bytes;      // accepted input bytes, ignored ones included
    int    cycles;
    item_t dump_words[$];

    class crash_tag_scoreboard;
        result_t     pending_tags[$];
        int          errors;

        phase_t      stage;
        logic [7:0]  pos;
        logic [7:0]  cur_type;
        logic [7:0]  cur_len;
        logic [8:0]  payload_left;
        logic [31:0] pc_shift;
        logic        pc_valid;
        logic [2:0]  done_status;

        function new();
            errors = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            stage        = PH_EVENT;
            pos          = '0;
            cur_type     = '0;
            cur_len      = '0;
            payload_left = '0;
            pc_shift     = '0;
            pc_valid     = 1'b0;
            done_status  = ST_RUNNING;
        endfunction

        function bit is_known(logic [7:0] t);
            return t >= T_FIRST_KNOWN && t <= T_LAST_KNOWN;
        endfunction

        function bit length_fits(logic [7:0] t, logic [7:0] len);
            if (!is_known(t))
                return 1'b1;
            return len == KNOWN_SIZE[t[2:0]] || (t == T_AUX_REGS && len == AUX_LONG_SIZE);
        endfunction

        // end mark inside a value: an unknown record that would use up the payload completes
        function logic [2:0] value_end_status();
            if (!is_known(cur_type) && int'(payload_left) <= int'(cur_len) + 2)
                return ST_COMPLETE;
            return ST_REC_ERR;
        endfunction

        // tag one accepted byte and queue the word it should produce
        function void note_byte(logic [7:0] b, logic eod);
            result_t    tag;
            logic [2:0] st;
            int         leftover;
            tag           = '0;
            st            = ST_RUNNING;
            tag.data_byte = b;
            case (stage)
                PH_EVENT:
                begin
                    tag.record_kind  = KIND_EVENT;
                    tag.value_offset = pos;
                    if (pos == 8'd0)
                        cur_type = b;
                    if (pos == 8'd1)
                        cur_len = b;
                    if (pos < HDR_LAST)
                    begin
                        pos++;
                        if (eod)
                            st = ST_HDR_TRUNC;
                    end
                    else if (cur_type != EVENT_CODE)
                        st = ST_BAD_CODE;
                    else if (int'(cur_len) <= EVENT_OVERHEAD)
                        st = ST_BAD_LEN;
                    else
                    begin
                        payload_left = 9'(int'(cur_len) - EVENT_OVERHEAD);
                        stage        = PH_RHDR;
                        pos          = '0;
                        cur_type     = '0;
                        cur_len      = '0;
                        if (eod)
                            st = ST_REC_ERR;
                    end
                end
                PH_RHDR:
                begin
                    tag.record_kind  = KIND_RHDR;
                    tag.value_offset = pos;
                    if (pos == 8'd0)
                    begin
                        cur_type        = b;
                        tag.record_type = b;
                        pos             = 8'd1;
                        if (eod)
                            st = ST_REC_ERR;
                    end
                    else
                    begin
                        tag.record_type = cur_type;
                        cur_len         = b;
                        if (!length_fits(cur_type, b) || b == 8'd0 ||
                            int'(b) > int'(payload_left))
                            st = ST_REC_ERR;
                        else
                        begin
                            stage = PH_VALUE;
                            pos   = '0;
                            if (eod)
                                st = value_end_status();
                        end
                    end
                end
                PH_VALUE:
                begin
                    tag.record_kind  = KIND_VALUE;
                    tag.record_type  = cur_type;
                    tag.value_offset = pos;
                    // second address-sized group of an aux record shifts in big-endian
                    if (cur_type == T_AUX_REGS && pos >= ADDR_BYTES && pos < 2 * ADDR_BYTES)
                    begin
                        pc_shift = {pc_shift[PC_W-9:0], b};
                        if (pos == 2 * ADDR_BYTES - 1)
                            pc_valid = 1'b1;
                    end
                    if (int'(pos) + 1 >= int'(cur_len))
                    begin
                        leftover = int'(payload_left) - int'(cur_len) - 2;
                        if (leftover <= 0)
                        begin
                            payload_left = '0;
                            st           = ST_COMPLETE;
                        end
                        else
                        begin
                            payload_left = 9'(leftover);
                            stage        = PH_RHDR;
                            pos          = '0;
                            if (eod)
                                st = ST_REC_ERR;
                        end
                    end
                    else
                    begin
                        pos++;
                        if (eod)
                            st = value_end_status();
                    end
                end
                default:
                begin
                    tag.record_kind = KIND_IGNORED;
                    st              = done_status;
                end
            endcase
            if (stage != PH_DONE && st != ST_RUNNING)
            begin
                tag.finished = 1'b1;
                done_status  = st;
                stage        = PH_DONE;
            end
            tag.status   = st;
            tag.pc_found = pc_valid;
            tag.pc_value = pc_valid ? pc_shift : '0;
            pending_tags.push_back(tag);
            if (eod)
                clear_parser();
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %h got %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
                                 logic last);
            result_t want;
            if (pending_tags.size() == 0)
            begin
                $display("%0t: word with nothing expected, expected none got tdata=%h tuser=%h",
                         $time, data, user);
                errors++;
                return;
            end
            want = pending_tags.pop_front();
            compare("record_kind", want.record_kind, user);
            compare("record_type", want.record_type, data[7:0]);
            compare("value_offset", want.value_offset, data[15:8]);
            compare("data_byte", want.data_byte, data[23:16]);
            compare("status", want.status, data[26:24]);
            compare("pc_found", want.pc_found, data[27]);
            compare("pc_value", want.pc_value, data[28 +: PC_W]);
            compare("tdata padding", '0, data[OUT_DATA_W-1:28+PC_W]);
            compare("finished", want.finished, last);
        endfunction
    endclass

    crash_tag_scoreboard sb;

    tlv_crash_record_parser_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // master side: check each word taken, then stall at random for the next edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tuser, m_tlast);
            m_tready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // offer one byte, holding it until the slave side takes the word
    task automatic send_byte(input logic [7:0] b, input logic eod);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eod;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b, eod);
        sent_bytes++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eod);
        item_t w;
        w.dump_byte   = b;
        w.end_of_dump = eod;
        dump_words.push_back(w);
    endtask

    task automatic send_dump();
        foreach (dump_words[i])
            send_byte(dump_words[i].dump_byte, dump_words[i].end_of_dump);
        dump_words.delete();
    endtask

    // one random dump: mostly well-formed record chains, some noise, cuts and corruption
    task automatic build_dump();
        int         mode;
        int         left;
        int         pick;
        int         n;
        logic [7:0] rtype;
        logic [7:0] rlen;
        mode = $urandom_range(0, 99);
        if (mode < 10)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        else
        begin
            left = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 252)
                                                : $urandom_range(1, 40);
            push_byte(EVENT_CODE, 1'b0);
            push_byte(8'(left + EVENT_OVERHEAD), 1'b0);
            for (int i = 0; i < 3; i++)
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            while (left > 0)
            begin
                pick  = $urandom_range(0, 9);
                rtype = 8'($urandom_range(int'(T_FIRST_KNOWN), int'(T_LAST_KNOWN)));
                if (pick < 6)
                begin
                    rlen = KNOWN_SIZE[rtype[2:0]];
                    if (rtype == T_AUX_REGS && $urandom_range(0, 1))
                        rlen = AUX_LONG_SIZE;
                end
                else if (pick < 9)
                    rlen = 8'($urandom_range(1, left < 24 ? left : 24));
                else
                    rlen = 8'($urandom_range(0, left + 2 > 255 ? 255 : left + 2));
                // unknown types where asked, or where a known size would overrun the payload
                if ((pick >= 6 && pick < 9) || (pick < 6 && int'(rlen) > left))
                begin
                    do
                        rtype = 8'($urandom_range(0, 255));
                    while (rtype >= T_FIRST_KNOWN && rtype <= T_LAST_KNOWN);
                    if (int'(rlen) > left)
                        rlen = 8'($urandom_range(1, left));
                end
                push_byte(rtype, 1'b0);
                push_byte(rlen, 1'b0);
                n = (rlen > 40) ? 8 : int'(rlen);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                left -= int'(rlen) + 2;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            if (mode < 25)
                dump_words[$urandom_range(0, dump_words.size() - 1)].dump_byte =
                    8'($urandom_range(0, 255));
            else if (mode < 40)
            begin
                n          = $urandom_range(1, dump_words.size());
                dump_words = dump_words[0:n-1];
            end
        end
        dump_words[dump_words.size() - 1].end_of_dump = 1'b1;
    endtask

    initial
    begin
        bit held;
        sb   = new();
        held = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // truncated header
        push_byte(EVENT_CODE, 1'b0);
        push_byte(8'h00, 1'b1);
        // bad event code
        push_byte(8'h00, 1'b0);
        push_byte(8'h08, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b1);
        // length too short
        push_byte(EVENT_CODE, 1'b0);
        push_byte(8'h03, 1'b0);
        repeat (2) push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // good header, end mark on its last byte
        push_byte(EVENT_CODE, 1'b0);
        push_byte(8'hFF, 1'b0);
        repeat (2) push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        // one-byte payload holding an unknown record that overruns it: complete
        push_byte(EVENT_CODE, 1'b0);
        push_byte(8'h04, 1'b0);
        repeat (3) push_byte(8'h5A, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hA5, 1'b1);
        send_dump();

        while (sent_bytes < RUN_BYTES)
        begin
            calm = sent_bytes >= 300 && sent_bytes < 600;
            // let the pipe run dry once with the sender parked
            if (!held && sent_bytes > 700)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending_tags.size() != 0);
                held = 1'b1;
            end
            build_dump();
            send_dump();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (sb.pending_tags.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tlvcr_pkg.sv
rtl/core/tlvcr_in_stage.sv
rtl/core/tlvcr_parse.sv
rtl/core/tlvcr_out_stage.sv
rtl/core/tlv_crash_record_parser_top.sv
test/tlv_crash_record_parser_top_test.sv
